/* rtl/core/imsk_pkg.sv */
// ----------------------------------------------------------------------------
// imsk_pkg
// shared types and constants for the interleaved multi-stack block
// ----------------------------------------------------------------------------
package imsk_pkg;

    localparam int MAX_STACKS_DEF = 8;
    localparam int MEM_DEPTH_DEF  = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int NS_W     = 4;
    localparam int ACT_W    = 2;
    localparam int SIDX_W   = 3;
    localparam int VAL_W    = 32;
    localparam int NS_RESET = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH = 2'd0,
        ACT_POP  = 2'd1,
        ACT_TOP  = 2'd2,
        ACT_NOP  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic wr;
        logic rd;
    } mem_cmd_t;

    typedef struct packed {
        status_t status;
        logic    hit;
    } result_t;

endpackage

/* rtl/core/imsk_ctrl.sv */
// ----------------------------------------------------------------------------
// imsk_ctrl
// per-stack counts, stride register and interleaved address generation
// ----------------------------------------------------------------------------
module imsk_ctrl #(
    parameter int MAX_STACKS = imsk_pkg::MAX_STACKS_DEF,
    parameter int MEM_DEPTH  = imsk_pkg::MEM_DEPTH_DEF,
    parameter int DATA_WIDTH = imsk_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  imsk_pkg::action_t               action,
    input  logic [imsk_pkg::SIDX_W-1:0]     stack_index,
    input  logic [imsk_pkg::VAL_W-1:0]      push_value,
    input  logic                            cfg_write,
    input  logic [imsk_pkg::NS_W-1:0]       cfg_data,
    output imsk_pkg::mem_cmd_t              mem_cmd,
    output logic [$clog2(MEM_DEPTH)-1:0]    mem_addr,
    output logic [DATA_WIDTH-1:0]           mem_wdata,
    output imsk_pkg::result_t               result
);
    import imsk_pkg::*;

    localparam int IDX_W  = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
    localparam int CNT_W  = $clog2(MEM_DEPTH + 1);
    localparam int AW     = $clog2(MEM_DEPTH);
    localparam int FULL_W = CNT_W + NS_W + 1;
    localparam logic [NS_W-1:0] NS_INIT =
        NS_W'((NS_RESET > MAX_STACKS) ? MAX_STACKS : NS_RESET);

    logic [NS_W-1:0]   ns_reg, ns_next;
    logic [CNT_W-1:0]  count_reg  [MAX_STACKS];
    logic [CNT_W-1:0]  count_next [MAX_STACKS];
    logic [IDX_W-1:0]  cidx;
    logic [6:0]        idx_w;
    logic              idx_ok;
    logic [CNT_W-1:0]  cnt_sel;
    logic [CNT_W-1:0]  slot;
    logic [FULL_W-1:0] addr_full;
    logic              in_range;
    logic              upd;
    logic [CNT_W-1:0]  cnt_new;
    logic [NS_W-1:0]   ns_fix;
    logic [63:0]       wide_val;

    assign idx_w   = 7'(stack_index);
    assign idx_ok  = (idx_w < 7'(ns_reg)) && (idx_w < 7'(MAX_STACKS));
    assign cidx    = IDX_W'(stack_index);
    assign cnt_sel = idx_ok ? count_reg[cidx] : '0;

    // push targets the next free slot, read top the last filled one
    assign slot      = (action == ACT_PUSH) ? cnt_sel : (cnt_sel - CNT_W'(1));
    assign addr_full = FULL_W'(stack_index) + FULL_W'(slot) * FULL_W'(ns_reg);
    assign in_range  = addr_full < FULL_W'(MEM_DEPTH);
    assign mem_addr  = addr_full[AW-1:0];
    assign wide_val  = 64'(push_value);
    assign mem_wdata = wide_val[DATA_WIDTH-1:0];

    always_comb
    begin
        result.status = ST_OK;
        result.hit    = 1'b0;
        mem_cmd.wr    = 1'b0;
        mem_cmd.rd    = 1'b0;
        upd           = 1'b0;
        cnt_new       = cnt_sel;
        if (action == ACT_NOP)
        begin
            result.status = ST_OK;
        end
        else if (!idx_ok)
        begin
            result.status = ST_BAD_INDEX;
        end
        else
        begin
            case (action)
                ACT_PUSH:
                begin
                    if (!in_range)
                    begin
                        result.status = ST_FULL;
                    end
                    else
                    begin
                        mem_cmd.wr = accept;
                        upd        = accept;
                        cnt_new    = cnt_sel + CNT_W'(1);
                    end
                end
                ACT_POP:
                begin
                    if (cnt_sel == '0)
                    begin
                        result.status = ST_EMPTY;
                    end
                    else
                    begin
                        upd     = accept;
                        cnt_new = cnt_sel - CNT_W'(1);
                    end
                end
                ACT_TOP:
                begin
                    if (cnt_sel == '0)
                    begin
                        result.status = ST_EMPTY;
                    end
                    else
                    begin
                        result.hit = in_range;
                        mem_cmd.rd = accept && in_range;
                    end
                end
                default:
                begin
                    result.status = ST_OK;
                end
            endcase
        end
    end

    // zero is held as one, above the stack count saturates
    always_comb
    begin
        if (cfg_data == '0)
        begin
            ns_fix = NS_W'(1);
        end
        else if (7'(cfg_data) > 7'(MAX_STACKS))
        begin
            ns_fix = NS_W'(MAX_STACKS);
        end
        else
        begin
            ns_fix = cfg_data;
        end
    end

    always_comb
    begin
        ns_next = cfg_write ? ns_fix : ns_reg;
        for (int i = 0; i < MAX_STACKS; i++)
        begin
            count_next[i] = count_reg[i];
        end
        if (cfg_write)
        begin
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                count_next[i] = '0;
            end
        end
        else if (upd)
        begin
            count_next[cidx] = cnt_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ns_reg <= NS_INIT;
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else
        begin
            ns_reg <= ns_next;
            for (int i = 0; i < MAX_STACKS; i++)
            begin
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

/* rtl/core/imsk_mem.sv */
// ----------------------------------------------------------------------------
// imsk_mem
// shared stack storage, single port with registered read data
// ----------------------------------------------------------------------------
module imsk_mem #(
    parameter int MEM_DEPTH  = imsk_pkg::MEM_DEPTH_DEF,
    parameter int DATA_WIDTH = imsk_pkg::DATA_WIDTH_DEF
) (
    input  logic                          clk,
    input  imsk_pkg::mem_cmd_t            mem_cmd,
    input  logic [$clog2(MEM_DEPTH)-1:0]  mem_addr,
    input  logic [DATA_WIDTH-1:0]         mem_wdata,
    output logic [DATA_WIDTH-1:0]         rdata
);
    import imsk_pkg::*;

    logic [DATA_WIDTH-1:0] mem_arr [MEM_DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_cmd.wr)
        begin
            mem_arr[mem_addr] <= mem_wdata;
        end
        if (mem_cmd.rd)
        begin
            rdata_reg <= mem_arr[mem_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/interleaved_multi_stack_top.sv */
// ----------------------------------------------------------------------------
// interleaved_multi_stack_top
// several lifo stacks interleaved in one shared memory
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after the input transaction
// throughput: one transaction per cycle while m_tready stays high, set by the
//   single memory port (one write or one read per request)
// reset: all stack counts cleared, num_stacks set to 3, memory left uncleared
// a num_stacks write takes effect from the next cycle and clears every count
// ----------------------------------------------------------------------------
module interleaved_multi_stack_top #(
    parameter int MAX_STACKS = imsk_pkg::MAX_STACKS_DEF,
    parameter int MEM_DEPTH  = imsk_pkg::MEM_DEPTH_DEF,
    parameter int DATA_WIDTH = imsk_pkg::DATA_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [31:0]                  s_tdata,   // push_value
    input  logic [4:0]                   s_tuser,   // action, stack_index
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // read_value
    output logic [1:0]                   m_tuser,   // status
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [imsk_pkg::NS_W-1:0]    cfg_data
);
    import imsk_pkg::*;

    logic                         accept;
    logic                         out_vld_reg, out_vld_next;
    status_t                      status_reg;
    logic                         hit_reg;
    mem_cmd_t                     mem_cmd;
    logic [$clog2(MEM_DEPTH)-1:0] mem_addr;
    logic [DATA_WIDTH-1:0]        mem_wdata;
    logic [DATA_WIDTH-1:0]        rdata;
    logic [63:0]                  rdata_ext;
    result_t                      result;
    action_t                      action;

    assign s_tready  = !out_vld_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign action    = action_t'(s_tuser[1:0]);

    imsk_ctrl #(
        .MAX_STACKS (MAX_STACKS),
        .MEM_DEPTH  (MEM_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .action      (action),
        .stack_index (s_tuser[4:2]),
        .push_value  (s_tdata),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .mem_cmd     (mem_cmd),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .result      (result)
    );

    imsk_mem #(
        .MEM_DEPTH  (MEM_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .clk       (clk),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .rdata     (rdata)
    );

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (accept)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= result.status;
            hit_reg    <= result.hit;
        end
    end

    assign rdata_ext = 64'(rdata);
    assign m_tvalid  = out_vld_reg;
    assign m_tuser   = status_reg;
    assign m_tdata   = hit_reg ? rdata_ext[31:0] : 32'd0;

endmodule
